### hdl/lru_write_back_cache_sim_core_macros.svh
// Assertion macros for the LRU write-back cache tag store checker.
// Included by the checker file only; depends on clk and rst in scope.
`ifndef LRU_WRITE_BACK_CACHE_SIM_CORE_MACROS_SVH
`define LRU_WRITE_BACK_CACHE_SIM_CORE_MACROS_SVH

// Property checked outside reset.
`define LWBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define LWBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/lwbc_pkg.sv
// Shared constants, types and helper functions of the LRU write-back cache.
// No dependencies; imported by every module of the block.
package lwbc_pkg;

  localparam int ADDR_W       = 30;
  localparam int WAYS_CFG_W   = 4;
  localparam int SETS_CFG_W   = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;
  localparam int TDATA_W      = 32;
  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_MAX_SETS = 256;

  localparam logic [CFG_IDX_W-1:0] REG_WAYS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETS = 1'b1;

  localparam logic EV_LOAD  = 1'b0;
  localparam logic EV_WBACK = 1'b1;
  localparam logic OP_WRITE = 1'b1;

  // Eviction outcome of one lookup.
  typedef struct packed {
    logic              wb;
    logic [ADDR_W-1:0] wb_addr;
  } evict_t;

  // Width of an index over n items, never below one bit.
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### hdl/lwbc_index.sv
// Set index unit: (address / ways) mod sets, one quotient bit per cycle.
// Depends on lwbc_pkg.
module lwbc_index #(
  parameter int MAX_SETS = lwbc_pkg::DEF_MAX_SETS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lwbc_pkg::ADDR_W-1:0]       addr,
  input  logic [lwbc_pkg::WAYS_CFG_W-1:0]   divisor,
  input  logic [lwbc_pkg::SETS_CFG_W-1:0]   modulus,
  output logic                              done,
  output logic [lwbc_pkg::idx_w(MAX_SETS)-1:0] idx
);
  import lwbc_pkg::*;

  localparam int SW  = idx_w(MAX_SETS);
  localparam int CNW = $clog2(ADDR_W + 1);

  logic                  busy;
  logic [CNW-1:0]        cnt;
  logic [ADDR_W-1:0]     dividend;
  logic [WAYS_CFG_W-1:0] rem;
  logic [SETS_CFG_W-1:0] setrem;

  logic [WAYS_CFG_W:0]   trial;
  logic                  qbit;
  logic [SETS_CFG_W:0]   strial;
  logic [WAYS_CFG_W-1:0] rem_next;
  logic [SETS_CFG_W-1:0] setrem_next;

  always_comb begin
    trial       = {rem, dividend[ADDR_W-1]};
    qbit        = (trial >= {1'b0, divisor});
    rem_next    = qbit ? WAYS_CFG_W'(trial - {1'b0, divisor}) : WAYS_CFG_W'(trial);
    // fold each quotient bit into the running remainder modulo sets
    strial      = {setrem, qbit};
    setrem_next = (strial >= {1'b0, modulus}) ? SETS_CFG_W'(strial - {1'b0, modulus})
                                              : SETS_CFG_W'(strial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        dividend <= addr;
        rem      <= '0;
        setrem   <= '0;
      end else if (busy) begin
        dividend <= {dividend[ADDR_W-2:0], 1'b0};
        rem      <= rem_next;
        setrem   <= setrem_next;
        cnt      <= cnt + 1'b1;
        if (cnt == CNW'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder is below the set count, so it always fits the index
  assign idx = SW'(setrem);

endmodule

### hdl/lwbc_store.sv
// Tag store memory: one row per set holding every way, registered read.
// Depends on lwbc_pkg; a row flag marks sets written since reset.
module lwbc_store #(
  parameter int MAX_WAYS = lwbc_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = lwbc_pkg::DEF_MAX_SETS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [lwbc_pkg::idx_w(MAX_SETS)-1:0]  rd_idx,
  output logic [MAX_WAYS*(lwbc_pkg::ADDR_W+2+lwbc_pkg::idx_w(MAX_WAYS))-1:0] rd_row,
  input  logic                                  wr_en,
  input  logic [lwbc_pkg::idx_w(MAX_SETS)-1:0]  wr_idx,
  input  logic [MAX_WAYS*(lwbc_pkg::ADDR_W+2+lwbc_pkg::idx_w(MAX_WAYS))-1:0] wr_row
);
  import lwbc_pkg::*;

  localparam int ROW_W = MAX_WAYS * (ADDR_W + 2 + idx_w(MAX_WAYS));

  logic [ROW_W-1:0]    mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_vld;
  logic [ROW_W-1:0]    rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_row;
    if (rd_en) rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) row_vld[wr_idx] <= 1'b1;
      if (rd_en) rd_vld <= row_vld[rd_idx];
    end
  end

  // a set never written reads as empty
  assign rd_row = rd_vld ? rd_q : '0;

endmodule

### hdl/lwbc_update.sv
// Lookup and LRU update of one set row: hit search, victim choice, new row.
// Depends on lwbc_pkg.
module lwbc_update #(
  parameter int MAX_WAYS = lwbc_pkg::DEF_MAX_WAYS
) (
  input  logic [MAX_WAYS*(lwbc_pkg::ADDR_W+2+lwbc_pkg::idx_w(MAX_WAYS))-1:0] row,
  input  logic [lwbc_pkg::ADDR_W-1:0]     addr,
  input  logic                            wr,
  input  logic [lwbc_pkg::WAYS_CFG_W-1:0] eff_w,
  output logic [MAX_WAYS*(lwbc_pkg::ADDR_W+2+lwbc_pkg::idx_w(MAX_WAYS))-1:0] new_row,
  output logic                            hit,
  output lwbc_pkg::evict_t                evict
);
  import lwbc_pkg::*;

  localparam int RW = idx_w(MAX_WAYS);
  localparam int EW = ADDR_W + 2 + RW;
  localparam int CW = $clog2(MAX_WAYS + 1);

  logic [MAX_WAYS-1:0]             vld, drt, nvld, ndrt;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] adr, nadr;
  logic [MAX_WAYS-1:0][RW-1:0]     rnk, nrnk;
  logic [CW-1:0]                   count;
  logic                            have_free, have_vic, do_evict;
  logic [RW-1:0]                   slot, free_s, vic, vrank, hrank;

  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    have_vic  = 1'b0;
    slot      = '0;
    free_s    = '0;
    vic       = '0;
    vrank     = '0;
    count     = '0;
    evict     = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      adr[i] = row[i*EW +: ADDR_W];
      vld[i] = row[i*EW + ADDR_W];
      drt[i] = row[i*EW + ADDR_W + 1];
      rnk[i] = row[i*EW + ADDR_W + 2 +: RW];
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (vld[i]) begin
        count = count + 1'b1;
        if (!hit && adr[i] == addr) begin
          hit  = 1'b1;
          slot = RW'(i);
        end
        if (!have_vic || rnk[i] > vrank) begin
          have_vic = 1'b1;
          vic      = RW'(i);
          vrank    = rnk[i];
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_s    = RW'(i);
      end
    end

    nadr     = adr;
    nvld     = vld;
    ndrt     = drt;
    nrnk     = rnk;
    hrank    = rnk[slot];
    do_evict = !hit && have_vic && (int'(count) >= int'(eff_w));

    if (hit) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (vld[i] && rnk[i] < hrank) nrnk[i] = rnk[i] + 1'b1;
      end
      nrnk[slot] = '0;
    end else begin
      if (do_evict) begin
        evict.wb      = drt[vic];
        evict.wb_addr = adr[vic];
        nvld[vic]     = 1'b0;
        slot          = vic;
      end else begin
        slot = free_s;
      end
      // age every remaining entry, then drop the new block in at the front
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (nvld[i]) nrnk[i] = rnk[i] + 1'b1;
      end
      nadr[slot] = addr;
      nvld[slot] = 1'b1;
      ndrt[slot] = 1'b0;
      nrnk[slot] = '0;
    end
    if (wr) ndrt[slot] = 1'b1;

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_row[i*EW +: EW] = {nrnk[i], ndrt[i], nvld[i], nadr[i]};
    end
  end

endmodule

### hdl/lru_write_back_cache_sim_core.sv
// LRU write-back cache tag store: one access in, zero to two memory events
// out (a write-back of a dirty victim, then a load). An access is accepted,
// passes the set index unit, which works out (address / ways) mod sets one
// quotient bit a cycle, has its set row read from the tag memory and is then
// looked up, updated and written back. Accesses are handled one at a time;
// the next is accepted while up to two events still drain from the output
// queue, and waits in the lookup step only if that queue has not yet emptied.
// A hit gives no event. Sets start empty after reset with no clearing pass.
// ways and sets are to be written on the config channel only while the
// block is idle, which it does not enforce; out-of-range values are clamped.
module lru_write_back_cache_sim_core #(
  parameter int MAX_WAYS = lwbc_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = lwbc_pkg::DEF_MAX_SETS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lwbc_pkg::TDATA_W-1:0]       s_tdata,   // [29:0] block_address
  input  logic                               s_tuser,   // [0] op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lwbc_pkg::TDATA_W-1:0]       m_tdata,   // [29:0] event_address
  output logic                               m_tuser,   // [0] event_kind
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lwbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lwbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lwbc_pkg::*;

  localparam int SW    = idx_w(MAX_SETS);
  localparam int ROW_W = MAX_WAYS * (ADDR_W + 2 + idx_w(MAX_WAYS));

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_LOOK} state_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } event_t;

  state_t                state;
  logic [WAYS_CFG_W-1:0] ways;
  logic [SETS_CFG_W-1:0] sets;
  logic [ADDR_W-1:0]     acc_addr;
  logic                  acc_wr;
  logic [1:0]            q_cnt;
  event_t                q0, q1;

  logic [WAYS_CFG_W-1:0] eff_w;
  logic [SETS_CFG_W-1:0] eff_s;
  logic                  s_acc, m_acc, div_done, commit, hit;
  logic [SW-1:0]         set_idx;
  logic [ROW_W-1:0]      rd_row, new_row;
  evict_t                evict;

  always_comb begin
    if (ways == '0) eff_w = WAYS_CFG_W'(1);
    else if (int'(ways) > MAX_WAYS) eff_w = WAYS_CFG_W'(MAX_WAYS);
    else eff_w = ways;
    if (sets == '0) eff_s = SETS_CFG_W'(1);
    else if (int'(sets) > MAX_SETS) eff_s = SETS_CFG_W'(MAX_SETS);
    else eff_s = sets;
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign m_tvalid  = (q_cnt != 2'd0);
  assign m_acc     = m_tvalid && m_tready;
  assign m_tdata   = TDATA_W'(q0.addr);
  assign m_tuser   = q0.kind;
  assign m_tlast   = q0.last;
  // hold the lookup until the previous events have all left
  assign commit    = (state == S_LOOK) && (q_cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ways <= WAYS_CFG_W'(8);
      sets <= SETS_CFG_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAYS: ways <= cfg_data[WAYS_CFG_W-1:0];
        REG_SETS: sets <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q_cnt <= 2'd0;
    end else begin
      case (state)
        S_IDLE: if (s_acc) state <= S_DIV;
        S_DIV:  if (div_done) state <= S_LOOK;
        S_LOOK: if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (commit && !hit) begin
        if (evict.wb) begin
          q0    <= '{kind: EV_WBACK, addr: evict.wb_addr, last: 1'b0};
          q1    <= '{kind: EV_LOAD, addr: acc_addr, last: 1'b1};
          q_cnt <= 2'd2;
        end else begin
          q0    <= '{kind: EV_LOAD, addr: acc_addr, last: 1'b1};
          q_cnt <= 2'd1;
        end
      end else if (m_acc) begin
        q0    <= q1;
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      acc_addr <= s_tdata[ADDR_W-1:0];
      acc_wr   <= (s_tuser == OP_WRITE);
    end
  end

  lwbc_index #(.MAX_SETS(MAX_SETS)) u_index (
    .clk     (clk),
    .rst     (rst),
    .start   (s_acc),
    .addr    (s_tdata[ADDR_W-1:0]),
    .divisor (eff_w),
    .modulus (eff_s),
    .done    (div_done),
    .idx     (set_idx)
  );

  lwbc_store #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (div_done),
    .rd_idx (set_idx),
    .rd_row (rd_row),
    .wr_en  (commit),
    .wr_idx (set_idx),
    .wr_row (new_row)
  );

  lwbc_update #(.MAX_WAYS(MAX_WAYS)) u_update (
    .row     (rd_row),
    .addr    (acc_addr),
    .wr      (acc_wr),
    .eff_w   (eff_w),
    .new_row (new_row),
    .hit     (hit),
    .evict   (evict)
  );

endmodule

### hdl/lwbc_checker.sv
// Port-level checker for the LRU write-back cache, bound to the top level.
// Depends on lwbc_pkg and lru_write_back_cache_sim_core_macros.svh.
`include "lru_write_back_cache_sim_core_macros.svh"

module lwbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [lwbc_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tuser,
  input logic                         m_tlast
);
  import lwbc_pkg::*;

  `LWBC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `LWBC_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
  `LWBC_ASSERT(a_one_access, s_tvalid && s_tready |=> !s_tready, "second access taken mid-lookup")
  `LWBC_ASSERT(a_first_is_wb, m_tvalid && !m_tlast |-> m_tuser == EV_WBACK, "non-final event is not a write-back")
  `LWBC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result shown after reset")

endmodule

bind lru_write_back_cache_sim_core lwbc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### tb/sv/testbench.sv
// Self-checking testbench of the LRU write-back cache tag store.
// Depends on lwbc_pkg and lru_write_back_cache_sim_core; predicts memory events in-line.
`timescale 1ns / 1ps

module testbench;
  import lwbc_pkg::*;

  localparam int NWAYS = DEF_MAX_WAYS;
  localparam int NSETS = DEF_MAX_SETS;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic              fin;
  } mem_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lru_write_back_cache_sim_core dut (.*);

  always #10 clk = ~clk;

  // Shadow tag store
  logic [ADDR_W-1:0] tag_addr [NWAYS*NSETS];
  logic              tag_valid[NWAYS*NSETS];
  logic              tag_dirty[NWAYS*NSETS];
  logic [2:0]        tag_rank [NWAYS*NSETS];
  logic [WAYS_CFG_W-1:0] ways_reg;
  logic [SETS_CFG_W-1:0] sets_reg;

  mem_event_t pending_events[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_req = 0;
  int hold_off_seen = 0;
  int hold_left = 0;

  task automatic predict_access(input logic wr, input logic [ADDR_W-1:0] a);
    int w, ns, base, cnt, slot, free_slot, victim;
    bit hit, have_free, have_victim;
    logic [2:0] vrank, r;
    mem_event_t ev;
    w = (ways_reg == 0) ? 1 : (ways_reg > NWAYS ? NWAYS : ways_reg);
    ns = (sets_reg == 0) ? 1 : (sets_reg > NSETS ? NSETS : sets_reg);
    base = ((a / w) % ns) * NWAYS;
    cnt = 0; slot = 0; free_slot = 0; victim = 0;
    hit = 0; have_free = 0; have_victim = 0; vrank = 0;
    for (int i = 0; i < NWAYS; i++) begin
      if (tag_valid[base+i]) begin
        cnt++;
        if (!hit && tag_addr[base+i] == a) begin
          hit = 1; slot = base + i;
        end
        if (!have_victim || tag_rank[base+i] > vrank) begin
          have_victim = 1; victim = base + i; vrank = tag_rank[base+i];
        end
      end else if (!have_free) begin
        have_free = 1; free_slot = base + i;
      end
    end
    if (hit) begin
      r = tag_rank[slot];
      for (int i = 0; i < NWAYS; i++)
        if (tag_valid[base+i] && tag_rank[base+i] < r) tag_rank[base+i]++;
      tag_rank[slot] = 0;
    end else begin
      if (cnt >= w && have_victim) begin
        if (tag_dirty[victim]) begin
          ev.kind = EV_WBACK; ev.addr = tag_addr[victim]; ev.fin = 1'b0;
          pending_events.push_back(ev);
        end
        tag_valid[victim] = 0;
        slot = victim;
      end else begin
        slot = free_slot;
      end
      for (int i = 0; i < NWAYS; i++)
        if (tag_valid[base+i]) tag_rank[base+i]++;
      tag_addr[slot] = a; tag_valid[slot] = 1; tag_dirty[slot] = 0; tag_rank[slot] = 0;
      ev.kind = EV_LOAD; ev.addr = a; ev.fin = 1'b1;
      pending_events.push_back(ev);
    end
    if (wr == OP_WRITE) tag_dirty[slot] = 1;
  endtask

  // valid stays up between back-to-back calls; drain drops it
  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= wr;
    s_tdata <= {{(TDATA_W-ADDR_W){1'b0}}, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_access(wr, a);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WAYS) ways_reg = val[WAYS_CFG_W-1:0];
    else sets_reg = val[SETS_CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // a hit in flight may still be busy inside the block
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] near_addr(input int span);
    return ADDR_W'($urandom_range(span));
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    mem_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event kind=%0d addr=%h last=%0d", m_tuser,
                   m_tdata[ADDR_W-1:0], m_tlast);
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== m_tuser || want.addr !== m_tdata[ADDR_W-1:0] ||
            want.fin !== m_tlast || m_tdata[TDATA_W-1:ADDR_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected kind=%0d addr=%h last=%0d, got %0d %h %0d",
                     want.kind, want.addr, want.fin, m_tuser, m_tdata, m_tlast);
        end
      end
    end
  end

  task automatic test_directed;
    // extreme addresses, both ops
    send_access(1'b0, '0);
    send_access(1'b1, '1);
    send_access(1'b1, 30'h2AAAAAAA);
    send_access(1'b0, 30'h15555555);
    send_access(1'b0, '0);            // hit
    // fill one set then evict dirty and clean victims (ways 8, stride 8*2048)
    for (int i = 0; i < 10; i++)
      send_access(i[0], ADDR_W'(30'h100 + i * 2048 * 8 / 8 * 8));
    send_access(1'b1, 30'h100);
    drain();
  endtask

  task automatic test_config_extremes;
    write_reg(REG_WAYS, 1); write_reg(REG_SETS, 1);
    for (int i = 0; i < 6; i++) send_access(i[0], ADDR_W'(i % 3));
    drain();
    write_reg(REG_WAYS, 0); write_reg(REG_SETS, 0);
    for (int i = 0; i < 4; i++) send_access(1'b1, ADDR_W'(i));
    drain();
    write_reg(REG_WAYS, 15); write_reg(REG_SETS, 511);
    for (int i = 0; i < 12; i++) send_access(1'b1, ADDR_W'(i * 8 * 256));
    drain();
    // ways lowered while a set is over capacity
    write_reg(REG_WAYS, 2);
    for (int i = 0; i < 4; i++) send_access(1'b0, ADDR_W'(30'h40000 + i * 512));
    drain();
  endtask

  task automatic run_random(input int n, input int wmax, input int smax, input int span);
    write_reg(REG_WAYS, $urandom_range(wmax));
    write_reg(REG_SETS, $urandom_range(smax));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_access(1'($urandom_range(1)), ADDR_W'($urandom));
      else send_access(1'($urandom_range(1)), near_addr(span));
    end
    drain();
  endtask

  task automatic test_random;
    send_idle_pct = 28; recv_idle_pct = 53;
    run_random(300, 8, 16, 200);
    run_random(150, 15, 511, 5000);
    send_idle_pct = 53; recv_idle_pct = 28;
    run_random(300, 4, 8, 100);
    run_random(150, 8, 256, 3000);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(300, 3, 4, 60);
    run_random(150, 8, 300, 100000);
  endtask

  task automatic test_back_pressure;
    hold_off_req++;
    for (int i = 0; i < 20; i++) send_access(1'b1, ADDR_W'(30'h3000000 + i * 97));
    drain();
  endtask

  initial begin
    for (int i = 0; i < NWAYS*NSETS; i++) begin
      tag_addr[i] = '0; tag_valid[i] = 0; tag_dirty[i] = 0; tag_rank[i] = 0;
    end
    ways_reg = 4'd8;
    sets_reg = 9'd256;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_back_pressure();
    test_random();
    if (mismatches == 0 && pending_events.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
